### src/cbz_pkg.sv
// ----------------------------------------------------------------------------
// cbz_pkg
// Shared widths, constants and types for the cubic Bezier point evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cbz_pkg;

    localparam int COORD_W = 16;           // signed Q12.4 coordinate
    localparam int T_W     = 17;           // unsigned Q1.16 parameter, clamped to 0..65536
    localparam int SQ_W    = 2 * T_W;      // square of a Q1.16 value
    localparam int W_W     = 49;           // Q1.48 weight, up to 2^48 inclusive
    localparam int ACC_W   = 67;           // signed weight * 3 * coordinate
    localparam int FRAC_W  = 48;           // fraction bits of the accumulator
    localparam int LATENCY = 5;            // start transfer to result strobe

    localparam logic [T_W-1:0]   T_ONE      = T_W'(65536);
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);

    // Four coordinates of one axis, start point first.
    typedef struct packed {
        logic signed [COORD_W-1:0] c0;
        logic signed [COORD_W-1:0] c1;
        logic signed [COORD_W-1:0] c2;
        logic signed [COORD_W-1:0] c3;
    } t_coord4;

    // Bernstein weights; the factor 3 of the middle terms is applied later.
    typedef struct packed {
        logic [W_W-1:0] w0;    // u^3
        logic [W_W-1:0] m1;    // u^2 t
        logic [W_W-1:0] m2;    // u t^2
        logic [W_W-1:0] w3;    // t^3
    } t_weights;

endpackage

`default_nettype wire

### src/cubic_bezier_point_eval.sv
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval
// Cubic Bezier point evaluator, fixed point, five-stage pipeline.
// ----------------------------------------------------------------------------
// A new item (four Q12.4 control points and a Q1.16 parameter t) may be
// transferred on every clock: start high while busy is low. The point is
// later shown on o_curve_x / o_curve_y for one cycle, flagged by o_valid;
// there is no back-pressure, so the receiver must take every result in
// that cycle. Throughput is one item per clock while busy is low. Of the
// pipeline stages, two build the Bernstein weights (squares, then cubes),
// one multiplies weights by coordinates, one adds pairs and the last adds
// and rounds into the output register. t above one is clamped to one.
// Rounding is to nearest with ties towards positive infinity. busy is
// high only in reset and until the release of reset is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_point_eval
    import cbz_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic signed [COORD_W-1:0] i_p0_x,
    input  wire logic signed [COORD_W-1:0] i_p0_y,
    input  wire logic signed [COORD_W-1:0] i_p1_x,
    input  wire logic signed [COORD_W-1:0] i_p1_y,
    input  wire logic signed [COORD_W-1:0] i_p2_x,
    input  wire logic signed [COORD_W-1:0] i_p2_y,
    input  wire logic signed [COORD_W-1:0] i_p3_x,
    input  wire logic signed [COORD_W-1:0] i_p3_y,
    input  wire logic        [T_W-1:0]     i_t_param,
    output logic                      o_valid,
    output logic signed [COORD_W-1:0] o_curve_x,
    output logic signed [COORD_W-1:0] o_curve_y
);

    logic     r_busy;
    logic     n_accept;
    logic     wgt_valid;
    t_weights wgt;
    t_coord4  n_px;
    t_coord4  n_py;
    // coordinates ride alongside the weight generator's two stages
    t_coord4  r_px_s1;
    t_coord4  r_py_s1;
    t_coord4  r_px_s2;
    t_coord4  r_py_s2;
    // valid bits for the three blend stages
    logic     r_vld_s3;
    logic     r_vld_s4;
    logic     r_vld_s5;

    // Held busy in reset and until it is seen released, so nothing is taken then.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign n_accept = start && !r_busy;

    assign n_px = '{c0: i_p0_x, c1: i_p1_x, c2: i_p2_x, c3: i_p3_x};
    assign n_py = '{c0: i_p0_y, c1: i_p1_y, c2: i_p2_y, c3: i_p3_y};

    // Stages 1 and 2: weights.
    cbz_weight_gen u_weight_gen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (n_accept),
        .i_t_param (i_t_param),
        .o_valid   (wgt_valid),
        .o_weights (wgt)
    );

    // Point data: no reset, qualified by the valid bits.
    always_ff @(posedge i_clk) begin
        r_px_s1 <= n_px;
        r_py_s1 <= n_py;
        r_px_s2 <= r_px_s1;
        r_py_s2 <= r_py_s1;
    end

    // Stages 3 to 5: one blend per axis sharing the same weights.
    cbz_blend u_blend_x (
        .i_clk     (i_clk),
        .i_weights (wgt),
        .i_coords  (r_px_s2),
        .o_result  (o_curve_x)
    );

    cbz_blend u_blend_y (
        .i_clk     (i_clk),
        .i_weights (wgt),
        .i_coords  (r_py_s2),
        .o_result  (o_curve_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_s3 <= 1'b0;
            r_vld_s4 <= 1'b0;
            r_vld_s5 <= 1'b0;
        end else begin
            r_vld_s3 <= wgt_valid;
            r_vld_s4 <= r_vld_s3;
            r_vld_s5 <= r_vld_s4;
        end
    end

    assign o_valid = r_vld_s5;

endmodule

`default_nettype wire

### src/cbz_weight_gen.sv
// ----------------------------------------------------------------------------
// cbz_weight_gen
// Two-stage weight generator: clamp t, squares, then cubes.
// ----------------------------------------------------------------------------
`default_nettype none

module cbz_weight_gen
    import cbz_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [T_W-1:0] i_t_param,
    output logic                o_valid,
    output t_weights            o_weights
);

    logic [T_W-1:0]  n_t;
    logic [T_W-1:0]  n_u;
    logic [T_W-1:0]  r_t;
    logic [T_W-1:0]  r_u;
    logic [SQ_W-1:0] r_uu;
    logic [SQ_W-1:0] r_tt;
    logic            r_vld_s1;
    logic            r_vld_s2;
    t_weights        n_w;
    t_weights        r_w;

    // stage 1: clamp t to one, u = 1 - t, squares
    assign n_t = (i_t_param > T_ONE) ? T_ONE : i_t_param;
    assign n_u = T_ONE - n_t;

    always_ff @(posedge i_clk) begin
        r_t  <= n_t;
        r_u  <= n_u;
        r_uu <= SQ_W'(n_u) * SQ_W'(n_u);
        r_tt <= SQ_W'(n_t) * SQ_W'(n_t);
    end

    // stage 2: cubes, all exact and at most 2^48
    always_comb begin
        n_w.w0 = W_W'(r_uu) * W_W'(r_u);
        n_w.m1 = W_W'(r_uu) * W_W'(r_t);
        n_w.m2 = W_W'(r_tt) * W_W'(r_u);
        n_w.w3 = W_W'(r_tt) * W_W'(r_t);
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_s1 <= 1'b0;
            r_vld_s2 <= 1'b0;
        end else begin
            r_vld_s1 <= i_valid;
            r_vld_s2 <= r_vld_s1;
        end
    end

    assign o_valid   = r_vld_s2;
    assign o_weights = r_w;

endmodule

`default_nettype wire

### src/cbz_blend.sv
// ----------------------------------------------------------------------------
// cbz_blend
// One axis: weighted products, pair sums, final sum with rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module cbz_blend
    import cbz_pkg::*;
(
    input  wire logic                i_clk,
    input  wire t_weights            i_weights,
    input  wire t_coord4             i_coords,
    output logic signed [COORD_W-1:0] o_result
);

    logic signed [COORD_W+1:0] n_c1x3;
    logic signed [COORD_W+1:0] n_c2x3;
    logic signed [ACC_W-1:0]   r_p0;
    logic signed [ACC_W-1:0]   r_p1;
    logic signed [ACC_W-1:0]   r_p2;
    logic signed [ACC_W-1:0]   r_p3;
    logic signed [ACC_W-1:0]   r_lo;
    logic signed [ACC_W-1:0]   r_hi;
    logic signed [ACC_W-1:0]   n_sum;
    logic signed [COORD_W-1:0] r_res;

    // 3 * c as shift and add
    assign n_c1x3 = (COORD_W+2)'(i_coords.c1) + ((COORD_W+2)'(i_coords.c1) <<< 1);
    assign n_c2x3 = (COORD_W+2)'(i_coords.c2) + ((COORD_W+2)'(i_coords.c2) <<< 1);

    // stage 3: four signed products, 50x16 and 50x18
    always_ff @(posedge i_clk) begin
        r_p0 <= ACC_W'($signed({1'b0, i_weights.w0})) * ACC_W'(i_coords.c0);
        r_p1 <= ACC_W'($signed({1'b0, i_weights.m1})) * ACC_W'(n_c1x3);
        r_p2 <= ACC_W'($signed({1'b0, i_weights.m2})) * ACC_W'(n_c2x3);
        r_p3 <= ACC_W'($signed({1'b0, i_weights.w3})) * ACC_W'(i_coords.c3);
    end

    // stage 4: pair sums
    always_ff @(posedge i_clk) begin
        r_lo <= r_p0 + r_p1;
        r_hi <= r_p2 + r_p3;
    end

    // stage 5: round to nearest, ties upward; the sum is a convex
    // combination, so bits above the result are pure sign
    assign n_sum = r_lo + r_hi + $signed(ROUND_HALF);

    always_ff @(posedge i_clk) begin
        r_res <= n_sum[FRAC_W+COORD_W-1:FRAC_W];
    end

    assign o_result = r_res;

endmodule

`default_nettype wire

### src/cbz_checker.sv
// ----------------------------------------------------------------------------
// cbz_checker
// Port-level checks on the point evaluator: timing and end-point results.
// ----------------------------------------------------------------------------
`default_nettype none

module cbz_checker
    import cbz_pkg::*;
(
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic signed [COORD_W-1:0]   i_p0_x,
    input wire logic signed [COORD_W-1:0]   i_p0_y,
    input wire logic signed [COORD_W-1:0]   i_p3_x,
    input wire logic signed [COORD_W-1:0]   i_p3_y,
    input wire logic        [T_W-1:0]       i_t_param,
    input wire logic                        o_valid,
    input wire logic signed [COORD_W-1:0]   o_curve_x,
    input wire logic signed [COORD_W-1:0]   o_curve_y
);

    logic xfer;
    assign xfer = i_rst_n && start && !busy;

    // every transfer gives exactly one result, and every result has a transfer
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer |-> ##LATENCY o_valid)
        else $error("result strobe missing after transfer");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(xfer, LATENCY))
        else $error("result strobe without a matching transfer");

    // t = 0 lands exactly on the start point
    a_t_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer && i_t_param == '0) |-> ##LATENCY
            (o_curve_x == $past(i_p0_x, LATENCY) && o_curve_y == $past(i_p0_y, LATENCY)))
        else $error("t of zero does not give the start point");

    // t of one or above lands exactly on the end point
    a_t_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer && i_t_param >= T_ONE) |-> ##LATENCY
            (o_curve_x == $past(i_p3_x, LATENCY) && o_curve_y == $past(i_p3_y, LATENCY)))
        else $error("t of one does not give the end point");

endmodule

bind cubic_bezier_point_eval cbz_checker u_cbz_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_p0_x    (i_p0_x),
    .i_p0_y    (i_p0_y),
    .i_p3_x    (i_p3_x),
    .i_p3_y    (i_p3_y),
    .i_t_param (i_t_param),
    .o_valid   (o_valid),
    .o_curve_x (o_curve_x),
    .o_curve_y (o_curve_y)
);

`default_nettype wire
